// ===== sv/rttcw_pkg.sv =====
package rttcw_pkg;

  localparam logic OP_ACK     = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic REG_SEGMENT_SIZE = 1'b0;
  localparam logic REG_WINDOW_LIMIT = 1'b1;

  localparam logic [13:0] SEGMENT_SIZE_RESET = 14'd1424;
  localparam logic [15:0] WINDOW_LIMIT_RESET = 16'd1;
  localparam logic [15:0] CWND_RESET         = 16'd1;
  localparam logic [29:0] SSTHRESH_RESET     = 30'd20000;
  localparam logic [31:0] RTO_RESET          = 32'd2001000;

  typedef struct packed {
    logic [15:0] cwnd;
    logic [29:0] ssthresh;
    logic [23:0] estimate;
    logic [23:0] deviation;
    logic [31:0] rto;
  } rtt_state_t;

  typedef struct packed {
    logic [15:0] send_window;
    logic        avoidance;
  } result_t;

endpackage

// ===== sv/rttcw_update.sv =====
module rttcw_update #(
  parameter int unsigned CWND_MAX = 65535
) (
  input  logic                 operation,
  input  logic [23:0]          sample_rtt_us,
  input  logic [31:0]          ack_number,
  input  logic [31:0]          next_sequence,
  input  logic [13:0]          segment_size,
  input  logic [15:0]          window_limit,
  input  rttcw_pkg::rtt_state_t state,
  output rttcw_pkg::rtt_state_t state_next,
  output rttcw_pkg::result_t    result
);
  import rttcw_pkg::*;

  localparam logic [15:0] CwndMax     = 16'(CWND_MAX);
  localparam logic [16:0] CwndMaxWide = 17'(CWND_MAX);

  logic [29:0] prod;
  logic [29:0] prod_max;
  logic [29:0] prod_half;
  logic        avoid_old;
  logic        grow;
  logic [16:0] cand;
  logic        cand_sat;
  logic [30:0] prod_cand;
  logic [30:0] prod_next;
  logic [27:0] est_sum;
  logic [23:0] est_ack;
  logic [23:0] diff;
  logic [26:0] dev_sum;
  logic [23:0] dev_ack;
  logic [26:0] rto_sum;

  // The product for the new window is derived from the old product, so
  // the multipliers all work in parallel on the current state.
  assign prod      = 30'(state.cwnd) * 30'(segment_size);
  assign prod_max  = 30'(CwndMax) * 30'(segment_size);
  assign prod_half = 30'(state.cwnd[15:1]) * 30'(segment_size);

  assign avoid_old = prod >= state.ssthresh;
  assign grow      = (operation == OP_ACK) && (ack_number >= next_sequence)
                     && (state.cwnd <= window_limit);
  assign cand      = avoid_old ? (17'(state.cwnd) + 17'd1) : {state.cwnd, 1'b0};
  assign cand_sat  = cand > CwndMaxWide;
  assign prod_cand = avoid_old ? (31'(prod) + 31'(segment_size)) : {prod, 1'b0};

  assign est_sum = {1'b0, state.estimate, 3'b000} - 28'(state.estimate)
                   + 28'(sample_rtt_us);
  assign est_ack = est_sum[26:3];
  assign diff    = (sample_rtt_us >= est_ack) ? (sample_rtt_us - est_ack)
                                              : (est_ack - sample_rtt_us);
  assign dev_sum = 27'({state.deviation, 1'b0}) + 27'(state.deviation) + 27'(diff);
  assign dev_ack = dev_sum[25:2];
  assign rto_sum = {3'b000, est_ack} + {1'b0, dev_ack, 2'b00};

  always_comb begin
    state_next = state;
    prod_next  = 31'(prod);
    if (operation == OP_TIMEOUT) begin
      state_next.cwnd     = CWND_RESET;
      state_next.ssthresh = prod_half;
      state_next.rto      = state.rto[31] ? '1 : {state.rto[30:0], 1'b0};
      prod_next           = 31'(segment_size);
    end else begin
      if (grow) begin
        state_next.cwnd = cand_sat ? CwndMax : cand[15:0];
        prod_next       = cand_sat ? 31'(prod_max) : prod_cand;
      end
      state_next.estimate  = est_ack;
      state_next.deviation = dev_ack;
      state_next.rto       = 32'(rto_sum);
    end
    result.avoidance   = prod_next >= 31'(state_next.ssthresh);
    result.send_window = (state_next.cwnd < window_limit) ? state_next.cwnd
                                                          : window_limit;
  end

endmodule

// ===== sv/rtt_timeout_and_congestion_window.sv =====
// Congestion window and retransmission timer, one event per transfer.
// An event passes through the input register and then the result register.
// Throughput is one event per cycle unless the receiver stalls; the state updates
// as an event leaves the input register, so the next event sees it at once.
// Reset (synchronous, active high) restores the window, threshold, timer and
// both configuration registers to their initial values and empties the pipeline.
module rtt_timeout_and_congestion_window #(
  parameter int unsigned CWND_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [23:0] sample_rtt_us,
  input  logic [31:0] ack_number,
  input  logic [31:0] next_sequence,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] congestion_window,
  output logic [29:0] threshold_bytes,
  output logic [31:0] timeout_us,
  output logic [15:0] send_window,
  output logic        avoidance_mode
);
  import rttcw_pkg::*;

  logic [13:0] segment_size;
  logic [15:0] window_limit;

  logic        s1_valid;
  logic        s1_operation;
  logic [23:0] s1_sample;
  logic [31:0] s1_ack;
  logic [31:0] s1_next_seq;

  rtt_state_t  state;
  rtt_state_t  state_next;
  result_t     result;
  logic        advance;
  logic        take;

  assign advance  = !out_valid || !out_stall;
  assign take     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  rttcw_update #(
    .CWND_MAX(CWND_MAX)
  ) u_update (
    .operation    (s1_operation),
    .sample_rtt_us(s1_sample),
    .ack_number   (s1_ack),
    .next_sequence(s1_next_seq),
    .segment_size (segment_size),
    .window_limit (window_limit),
    .state        (state),
    .state_next   (state_next),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      segment_size   <= SEGMENT_SIZE_RESET;
      window_limit   <= WINDOW_LIMIT_RESET;
      state.cwnd      <= CWND_RESET;
      state.ssthresh  <= SSTHRESH_RESET;
      state.estimate  <= '0;
      state.deviation <= '0;
      state.rto       <= RTO_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (take) begin
        state <= state_next;
      end
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_SEGMENT_SIZE: segment_size <= cfg_data[13:0];
          REG_WINDOW_LIMIT: window_limit <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_operation <= operation;
      s1_sample    <= sample_rtt_us;
      s1_ack       <= ack_number;
      s1_next_seq  <= next_sequence;
    end
    if (take) begin
      congestion_window <= state_next.cwnd;
      threshold_bytes   <= state_next.ssthresh;
      timeout_us        <= state_next.rto;
      send_window       <= result.send_window;
      avoidance_mode    <= result.avoidance;
    end
  end

  // The window never leaves its legal range.
  assert property (@(posedge clk) disable iff (rst)
    (state.cwnd != 16'd0) && (32'(state.cwnd) <= CWND_MAX))
    else $error("congestion window out of range");

  // A timeout event leaves a window of one in the result register.
  assert property (@(posedge clk) disable iff (rst)
    (take && (s1_operation == OP_TIMEOUT)) |=> (out_valid && (congestion_window == CWND_RESET)))
    else $error("timeout did not reset the window");

  // The send window never exceeds the congestion window.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (send_window <= congestion_window))
    else $error("send window above congestion window");

  // The input side stalls only when the input register is holding an event.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("stall without a held event");

endmodule

// ===== tb/tb.sv =====
module tb;
  import rttcw_pkg::*;

  localparam int unsigned WINDOW_CAP = 65535;
  localparam int unsigned STALL_PCT = 13;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned EVENTS_PER_PHASE = 150;

  typedef struct packed {
    logic        op;
    logic [23:0] sample;
    logic [31:0] ack_number;
    logic [31:0] next_sequence;
  } congestion_event_t;

  typedef struct packed {
    logic [15:0] window;
    logic [29:0] threshold;
    logic [31:0] timeout;
    logic [15:0] send_window;
    logic        avoidance;
  } window_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_enable = 1'b0;
  logic cfg_index = REG_SEGMENT_SIZE;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic operation = OP_ACK;
  logic [23:0] sample_rtt_us = '0;
  logic [31:0] ack_number = '0;
  logic [31:0] next_sequence = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] congestion_window;
  logic [29:0] threshold_bytes;
  logic [31:0] timeout_us;
  logic [15:0] send_window;
  logic avoidance_mode;

  congestion_event_t events_to_send[$];
  window_report_t window_reports_due[$];
  congestion_event_t next_event;
  logic in_taken = 1'b0;
  int unsigned events_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  logic calm;

  logic [15:0] cwnd;
  logic [29:0] ssthresh;
  logic [23:0] rtt_est;
  logic [23:0] rtt_dev;
  logic [31:0] rto;
  logic [13:0] seg_size;
  logic [15:0] win_limit;

  rtt_timeout_and_congestion_window #(
    .CWND_MAX(WINDOW_CAP)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .sample_rtt_us(sample_rtt_us),
    .ack_number(ack_number),
    .next_sequence(next_sequence),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .congestion_window(congestion_window),
    .threshold_bytes(threshold_bytes),
    .timeout_us(timeout_us),
    .send_window(send_window),
    .avoidance_mode(avoidance_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (events_accepted >= 600) && (events_accepted < 800);

  function automatic window_report_t apply_event(congestion_event_t ev);
    window_report_t r;
    logic [63:0] bytes;
    logic [31:0] grown;
    logic [31:0] sum;
    logic [23:0] diff;
    if (ev.op == OP_TIMEOUT) begin
      ssthresh = (cwnd >> 1) * seg_size;
      cwnd = 16'd1;
      rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : (rto << 1);
    end else begin
      if (ev.ack_number >= ev.next_sequence && cwnd <= win_limit) begin
        bytes = 64'(cwnd) * 64'(seg_size);
        grown = (bytes >= 64'(ssthresh)) ? 32'(cwnd) + 32'd1 : 32'(cwnd) << 1;
        cwnd = (grown > WINDOW_CAP) ? 16'(WINDOW_CAP) : grown[15:0];
      end
      sum = 32'(rtt_est) * 32'd7 + 32'(ev.sample);
      rtt_est = sum[26:3];
      diff = (ev.sample >= rtt_est) ? ev.sample - rtt_est : rtt_est - ev.sample;
      sum = 32'(rtt_dev) * 32'd3 + 32'(diff);
      rtt_dev = sum[25:2];
      rto = 32'(rtt_est) + (32'(rtt_dev) << 2);
    end
    bytes = 64'(cwnd) * 64'(seg_size);
    r.window = cwnd;
    r.threshold = ssthresh;
    r.timeout = rto;
    r.send_window = (cwnd < win_limit) ? cwnd : win_limit;
    r.avoidance = (bytes >= 64'(ssthresh));
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatch_count < 100) begin
      $display("MISMATCH at %0t: %s got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic compare_report(window_report_t want);
    if (congestion_window !== want.window) begin
      report_mismatch("congestion_window", congestion_window, want.window);
    end
    if (threshold_bytes !== want.threshold) begin
      report_mismatch("threshold_bytes", threshold_bytes, want.threshold);
    end
    if (timeout_us !== want.timeout) begin
      report_mismatch("timeout_us", timeout_us, want.timeout);
    end
    if (send_window !== want.send_window) begin
      report_mismatch("send_window", send_window, want.send_window);
    end
    if (avoidance_mode !== want.avoidance) begin
      report_mismatch("avoidance_mode", avoidance_mode, want.avoidance);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cwnd = CWND_RESET;
      ssthresh = SSTHRESH_RESET;
      rtt_est = '0;
      rtt_dev = '0;
      rto = RTO_RESET;
      seg_size = SEGMENT_SIZE_RESET;
      win_limit = WINDOW_LIMIT_RESET;
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_write_enable) begin
        if (cfg_index == REG_SEGMENT_SIZE) begin
          seg_size = cfg_data[13:0];
        end else begin
          win_limit = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        window_reports_due.push_back(apply_event({operation, sample_rtt_us, ack_number,
                                                  next_sequence}));
        events_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (window_reports_due.size() == 0) begin
          report_mismatch("result with nothing due, congestion_window", congestion_window, 0);
        end else begin
          compare_report(window_reports_due.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (events_to_send.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
        next_event = events_to_send.pop_front();
        in_valid <= 1'b1;
        operation <= next_event.op;
        sample_rtt_us <= next_event.sample;
        ack_number <= next_event.ack_number;
        next_sequence <= next_event.next_sequence;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver holds off once for a long stretch so the pipeline fills and
  // the block stalls the next transfer.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && events_accepted >= 400) begin
      hold_done <= 1'b1;
      hold_left <= 80;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  function automatic congestion_event_t ack_event(logic [23:0] s, logic [31:0] a,
                                                  logic [31:0] n);
    congestion_event_t ev;
    ev.op = OP_ACK;
    ev.sample = s;
    ev.ack_number = a;
    ev.next_sequence = n;
    return ev;
  endfunction

  function automatic congestion_event_t timeout_event(logic [31:0] fill);
    congestion_event_t ev;
    ev.op = OP_TIMEOUT;
    ev.sample = fill[23:0];
    ev.ack_number = fill;
    ev.next_sequence = ~fill;
    return ev;
  endfunction

  function automatic congestion_event_t random_event();
    congestion_event_t ev;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned pick;
    a = $urandom;
    b = $urandom;
    pick = $urandom_range(0, 99);
    ev.op = (pick < 15) ? OP_TIMEOUT : OP_ACK;
    pick = $urandom_range(0, 9);
    case (pick)
      0: ev.sample = '0;
      1: ev.sample = '1;
      2, 3: ev.sample = 24'($urandom);
      default: ev.sample = 24'($urandom_range(0, 400000));
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      b = a;
    end
    if (pick >= 80) begin
      ev.ack_number = (a < b) ? a : b;
      ev.next_sequence = (a < b) ? b : a;
    end else begin
      ev.ack_number = (a < b) ? b : a;
      ev.next_sequence = (a < b) ? a : b;
    end
    return ev;
  endfunction

  task automatic wait_drained();
    while (events_to_send.size() != 0 || in_valid || window_reports_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic program_register(logic idx, logic [15:0] value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    logic [15:0] seg_plan [8];
    logic [15:0] limit_plan [8];
    seg_plan = '{16'd1424, 16'd1, 16'd16383, 16'd0, 16'd0, 16'd536, 16'd16383, 16'd0};
    limit_plan = '{16'd64, 16'd65535, 16'd65535, 16'd300, 16'd0, 16'd8, 16'd1, 16'd0};
    seg_plan[4] = 16'($urandom_range(0, 16383));
    seg_plan[7] = 16'($urandom_range(0, 16383));
    limit_plan[4] = 16'($urandom_range(0, 65535));
    limit_plan[7] = 16'($urandom_range(0, 65535));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    events_to_send.push_back(ack_event('0, '0, '0));
    events_to_send.push_back(ack_event('1, '1, '1));
    for (int i = 0; i < 10; i++) begin
      events_to_send.push_back(timeout_event(i[0] ? '1 : '0));
    end
    events_to_send.push_back(ack_event(24'd12345, 32'd0, 32'hFFFF_FFFF));
    events_to_send.push_back(ack_event(24'd800, 32'd5000, 32'd4999));
    events_to_send.push_back(timeout_event(32'h5A5A_A5A5));
    wait_drained();

    program_register(REG_SEGMENT_SIZE, 16'd0);
    program_register(REG_WINDOW_LIMIT, 16'hFFFF);
    for (int i = 0; i < 17; i++) begin
      events_to_send.push_back(ack_event(24'(1000 * i), 32'(i + 1), 32'(i)));
    end
    wait_drained();

    program_register(REG_SEGMENT_SIZE, 16'd16383);
    events_to_send.push_back(ack_event(24'd2000, 32'd100, 32'd100));
    events_to_send.push_back(timeout_event('0));
    wait_drained();

    program_register(REG_WINDOW_LIMIT, 16'd0);
    events_to_send.push_back(ack_event(24'd3000, 32'd7, 32'd3));

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      program_register(REG_SEGMENT_SIZE, seg_plan[p]);
      program_register(REG_WINDOW_LIMIT, limit_plan[p]);
      for (int i = 0; i < EVENTS_PER_PHASE; i++) begin
        events_to_send.push_back(random_event());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
